### rtl/core/brs_pkg.sv
package brs_pkg;

	// Field and datapath widths
	localparam int CORDIC_STAGES_DEF = 16;
	localparam int TABLE_LEN         = 24;
	localparam int IDX_W             = 5;
	localparam int CNT_W             = 5;
	localparam int SQRT_STEPS        = 32;
	localparam int DIV_STEPS         = 31;
	localparam int CW                = 34;
	localparam logic signed [CW-1:0] CORDIC_GAIN = 34'sd652032875;
	localparam logic signed [CW-1:0] ONE_Q30     = 34'sd1073741824;

	// Arctangent of 2^-i in 2^-32 turns
	function automatic logic [29:0] atan_turn(input logic [IDX_W-1:0] i);
		logic [29:0] r;
		case (i)
			5'd0:  r = 30'd536870912;
			5'd1:  r = 30'd316933406;
			5'd2:  r = 30'd167458907;
			5'd3:  r = 30'd85004756;
			5'd4:  r = 30'd42667331;
			5'd5:  r = 30'd21354465;
			5'd6:  r = 30'd10679838;
			5'd7:  r = 30'd5340245;
			5'd8:  r = 30'd2670162;
			5'd9:  r = 30'd1335087;
			5'd10: r = 30'd667544;
			5'd11: r = 30'd333772;
			5'd12: r = 30'd166886;
			5'd13: r = 30'd83443;
			5'd14: r = 30'd41722;
			5'd15: r = 30'd20861;
			5'd16: r = 30'd10430;
			5'd17: r = 30'd5215;
			5'd18: r = 30'd2608;
			5'd19: r = 30'd1304;
			5'd20: r = 30'd652;
			5'd21: r = 30'd326;
			5'd22: r = 30'd163;
			5'd23: r = 30'd81;
			default: r = 30'd0;
		endcase
		return r;
	endfunction

	// Configuration register indexes
	typedef enum logic [2:0] {
		REG_CHEM_SHIFT = 3'd0,
		REG_POS_X      = 3'd1,
		REG_POS_Y      = 3'd2,
		REG_POS_Z      = 3'd3,
		REG_TIME_STEP  = 3'd4,
		REG_INIT_MX    = 3'd5,
		REG_INIT_MY    = 3'd6,
		REG_INIT_MZ    = 3'd7
	} cfg_reg_t;

	// Multiplier micro steps, in issue order
	typedef enum logic [4:0] {
		MS_NOP, MS_BX, MS_BY, MS_GX, MS_GY, MS_GZ, MS_BX2, MS_BY2, MS_BZ2,
		MS_ANG,
		MS_DX, MS_DY, MS_DZ, MS_G,
		MS_XC1, MS_XC2, MS_XT2, MS_XT1, MS_XT3,
		MS_YC1, MS_YC2, MS_YT2, MS_YT1, MS_YT3,
		MS_ZC1, MS_ZC2, MS_ZT2, MS_ZT1, MS_ZT3
	} mstep_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_CINI, ST_CROT, ST_MUL, ST_SQI, ST_SQ, ST_CHK,
		ST_DVI, ST_DV, ST_CMT, ST_FIN
	} st_t;

	typedef struct packed {
		logic             load;
		logic             cor_init;
		logic             cor_rot;
		logic             cor_step;
		logic [IDX_W-1:0] cor_idx;
		mstep_t           mstep;
		logic             sq_init;
		logic             sq_step;
		logic             dv_init;
		logic             dv_step;
		logic             commit;
		logic             out_load;
	} cmd_t;

	typedef struct packed {
		logic norm_zero;
	} sts_t;

endpackage

### rtl/core/brs_cordic.sv
module brs_cordic import brs_pkg::*; (
	input  logic                 clk,
	input  logic                 init,
	input  logic                 step,
	input  logic [31:0]          ang,
	input  logic [IDX_W-1:0]     idx,
	output logic signed [CW-1:0] cos_o,
	output logic signed [CW-1:0] sin_o
);

	logic signed [CW-1:0] x_q, y_q, z_q;
	logic                 neg_q;
	logic                 fold;
	logic [31:0]          ang_f;
	logic signed [CW-1:0] dx, dy, at;

	// Fold second and third quadrant onto the others, negate at the end
	assign fold  = (ang[31:30] == 2'd1) || (ang[31:30] == 2'd2);
	assign ang_f = fold ? ang - 32'h8000_0000 : ang;

	assign dx = y_q >>> idx;
	assign dy = x_q >>> idx;
	assign at = CW'(atan_turn(idx));

	// One micro-rotation per step
	always_ff @(posedge clk) begin
		if (init) begin
			x_q   <= CORDIC_GAIN;
			y_q   <= '0;
			z_q   <= CW'($signed(ang_f));
			neg_q <= fold;
		end else if (step) begin
			if (!z_q[CW-1]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	assign cos_o = neg_q ? -x_q : x_q;
	assign sin_o = neg_q ? -y_q : y_q;

endmodule

### rtl/core/brs_sqrt.sv
module brs_sqrt import brs_pkg::*; (
	input  logic        clk,
	input  logic        init,
	input  logic        step,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	logic [63:0] v_q, res_q, bit_q;
	logic [64:0] trial;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};

	// Digit-by-digit root, one result bit per step
	always_ff @(posedge clk) begin
		if (init) begin
			v_q   <= rad;
			res_q <= '0;
			bit_q <= 64'h4000_0000_0000_0000;
		end else if (step) begin
			if ({1'b0, v_q} >= trial) begin
				v_q   <= v_q - trial[63:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign root = res_q[31:0];

endmodule

### rtl/core/brs_divider.sv
module brs_divider import brs_pkg::*; (
	input  logic               clk,
	input  logic               init,
	input  logic               step,
	input  logic signed [31:0] b_x,
	input  logic signed [31:0] b_y,
	input  logic signed [31:0] b_z,
	input  logic [31:0]        norm,
	output logic signed [31:0] n_x,
	output logic signed [31:0] n_y,
	output logic signed [31:0] n_z
);

	logic signed [31:0] b_in [3];
	logic signed [31:0] n_out [3];

	assign b_in[0] = b_x;
	assign b_in[1] = b_y;
	assign b_in[2] = b_z;
	assign n_x = n_out[0];
	assign n_y = n_out[1];
	assign n_z = n_out[2];

	// Three restoring dividers, rounded |b|*2^30/norm, one quotient bit a step
	for (genvar k = 0; k < 3; k++) begin : g_lane
		logic [31:0] rem_q;
		logic [30:0] sh_q;
		logic        neg_q;
		logic [31:0] mag;
		logic [62:0] num;
		logic [32:0] r2, r2_sub;

		assign mag    = b_in[k][31] ? (~b_in[k] + 32'd1) : b_in[k];
		assign num    = {1'b0, mag, 30'b0} + {32'b0, norm[31:1]};
		assign r2     = {rem_q, sh_q[30]};
		assign r2_sub = r2 - {1'b0, norm};

		always_ff @(posedge clk) begin
			if (init) begin
				rem_q <= num[62:31];
				sh_q  <= num[30:0];
				neg_q <= b_in[k][31];
			end else if (step) begin
				if (r2 >= {1'b0, norm}) begin
					rem_q <= r2_sub[31:0];
					sh_q  <= {sh_q[29:0], 1'b1};
				end else begin
					rem_q <= r2[31:0];
					sh_q  <= {sh_q[29:0], 1'b0};
				end
			end
		end

		assign n_out[k] = neg_q ? -$signed({1'b0, sh_q}) : $signed({1'b0, sh_q});
	end

endmodule

### rtl/core/brs_datapath.sv
module brs_datapath import brs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  cmd_t               cmd,
	output sts_t               sts,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	input  logic signed [15:0] rf_amplitude,
	input  logic [15:0]        rf_phase,
	input  logic signed [15:0] grad_x,
	input  logic signed [15:0] grad_y,
	input  logic signed [15:0] grad_z,
	input  logic               restart,
	output logic signed [15:0] mag_x,
	output logic signed [15:0] mag_y,
	output logic signed [15:0] mag_z
);

	localparam int AW = 72;
	localparam logic signed [AW-1:0] H13 = 72'sd8192;
	localparam logic signed [AW-1:0] H15 = 72'sd32768;
	localparam logic signed [AW-1:0] H21 = 72'sd2097152;
	localparam logic signed [AW-1:0] H27 = 72'sd134217728;
	localparam logic signed [AW-1:0] H29 = 72'sd536870912;
	localparam logic signed [AW-1:0] MAX32 = 72'sd2147483647;
	localparam logic signed [AW-1:0] MIN32 = -72'sd2147483648;
	localparam logic signed [AW-1:0] MAX16 = 72'sd32767;
	localparam logic signed [AW-1:0] MIN16 = -72'sd32768;

	// Configuration registers
	logic signed [15:0] cs_q, px_q, py_q, pz_q, imx_q, imy_q, imz_q;
	logic [15:0]        dt_q;

	// Item and state registers
	logic signed [15:0] amp_q, gx_q, gy_q, gz_q;
	logic [15:0]        ph_q;
	logic signed [15:0] mag_x_q, mag_y_q, mag_z_q;
	logic signed [15:0] res_x_q, res_y_q, res_z_q;
	logic signed [15:0] out_x_q, out_y_q, out_z_q;
	logic signed [25:0] bx_q, by_q;
	logic signed [31:0] bz_q;
	logic signed [AW-1:0] acc_q;
	logic [31:0]        ang_q;
	logic signed [33:0] rdot_q, g28_q, crr_q;

	// Multiplier
	logic signed [35:0] mul_a;
	logic signed [33:0] mul_b;
	logic signed [69:0] prod_s1;
	mstep_t             mstep_s1;

	logic signed [CW-1:0] cos_w, sin_w;
	logic [31:0]          cor_ang, norm;
	logic signed [31:0]   nx, ny, nz;

	logic signed [AW-1:0] p_w, r14, r22, r28, r30, sum_p, dif_p, sum_r28;
	logic signed [AW-1:0] rd16_sum, rd16_r28, rd14_dif, ang_w, cs_w;
	logic signed [31:0]   bz_sat;
	logic signed [15:0]   res_sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cs_q  <= '0;
			px_q  <= '0;
			py_q  <= '0;
			pz_q  <= '0;
			dt_q  <= 16'd1024;
			imx_q <= '0;
			imy_q <= '0;
			imz_q <= 16'sd16384;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_CHEM_SHIFT: cs_q  <= cfg_data;
				REG_POS_X:      px_q  <= cfg_data;
				REG_POS_Y:      py_q  <= cfg_data;
				REG_POS_Z:      pz_q  <= cfg_data;
				REG_TIME_STEP:  dt_q  <= cfg_data;
				REG_INIT_MX:    imx_q <= cfg_data;
				REG_INIT_MY:    imy_q <= cfg_data;
				REG_INIT_MZ:    imz_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Iterative units
	assign cor_ang = cmd.cor_rot ? ang_q : {ph_q, 16'b0};

	brs_cordic u_cordic (
		.clk   (clk),
		.init  (cmd.cor_init),
		.step  (cmd.cor_step),
		.ang   (cor_ang),
		.idx   (cmd.cor_idx),
		.cos_o (cos_w),
		.sin_o (sin_w)
	);

	brs_sqrt u_sqrt (
		.clk  (clk),
		.init (cmd.sq_init),
		.step (cmd.sq_step),
		.rad  (acc_q[63:0]),
		.root (norm)
	);

	brs_divider u_div (
		.clk  (clk),
		.init (cmd.dv_init),
		.step (cmd.dv_step),
		.b_x  (32'(bx_q)),
		.b_y  (32'(by_q)),
		.b_z  (bz_q),
		.norm (norm),
		.n_x  (nx),
		.n_y  (ny),
		.n_z  (nz)
	);

	assign sts.norm_zero = (norm == 32'd0);

	// Operand select for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (cmd.mstep)
			MS_BX:  begin mul_a = 36'(amp_q); mul_b = cos_w; end
			MS_BY:  begin mul_a = 36'(amp_q); mul_b = sin_w; end
			MS_GX:  begin mul_a = 36'(gx_q); mul_b = 34'(px_q); end
			MS_GY:  begin mul_a = 36'(gy_q); mul_b = 34'(py_q); end
			MS_GZ:  begin mul_a = 36'(gz_q); mul_b = 34'(pz_q); end
			MS_BX2: begin mul_a = 36'(bx_q); mul_b = 34'(bx_q); end
			MS_BY2: begin mul_a = 36'(by_q); mul_b = 34'(by_q); end
			MS_BZ2: begin mul_a = 36'(bz_q); mul_b = 34'(bz_q); end
			MS_ANG: begin mul_a = {4'b0, norm}; mul_b = {18'b0, dt_q}; end
			MS_DX:  begin mul_a = 36'(nx); mul_b = 34'(mag_x_q); end
			MS_DY:  begin mul_a = 36'(ny); mul_b = 34'(mag_y_q); end
			MS_DZ:  begin mul_a = 36'(nz); mul_b = 34'(mag_z_q); end
			MS_G:   begin mul_a = 36'(rdot_q); mul_b = ONE_Q30 - cos_w; end
			MS_XC1: begin mul_a = 36'(ny); mul_b = 34'(mag_z_q); end
			MS_XC2: begin mul_a = 36'(nz); mul_b = 34'(mag_y_q); end
			MS_YC1: begin mul_a = 36'(nz); mul_b = 34'(mag_x_q); end
			MS_YC2: begin mul_a = 36'(nx); mul_b = 34'(mag_z_q); end
			MS_ZC1: begin mul_a = 36'(nx); mul_b = 34'(mag_y_q); end
			MS_ZC2: begin mul_a = 36'(ny); mul_b = 34'(mag_x_q); end
			MS_XT2, MS_YT2, MS_ZT2: begin mul_a = 36'(crr_q); mul_b = sin_w; end
			MS_XT1: begin mul_a = 36'(mag_x_q); mul_b = cos_w; end
			MS_YT1: begin mul_a = 36'(mag_y_q); mul_b = cos_w; end
			MS_ZT1: begin mul_a = 36'(mag_z_q); mul_b = cos_w; end
			MS_XT3: begin mul_a = 36'(g28_q); mul_b = 34'(nx); end
			MS_YT3: begin mul_a = 36'(g28_q); mul_b = 34'(ny); end
			MS_ZT3: begin mul_a = 36'(g28_q); mul_b = 34'(nz); end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mstep_s1 <= MS_NOP;
		end else begin
			mstep_s1 <= cmd.mstep;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= 70'(mul_a * mul_b);
	end

	// Rescales of the product, rounding half up
	assign p_w      = AW'(prod_s1);
	assign r14      = (p_w + H13) >>> 14;
	assign r22      = (p_w + H21) >>> 22;
	assign r28      = (p_w + H27) >>> 28;
	assign r30      = (p_w + H29) >>> 30;
	assign sum_p    = acc_q + p_w;
	assign dif_p    = acc_q - p_w;
	assign sum_r28  = acc_q + r28;
	assign rd16_sum = (sum_p + H15) >>> 16;
	assign rd16_r28 = (sum_r28 + H15) >>> 16;
	assign rd14_dif = (dif_p + H13) >>> 14;
	assign ang_w    = (p_w + 72'sd8) >>> 4;
	assign cs_w     = $signed({{48{cs_q[15]}}, cs_q, 8'b0});

	always_comb begin
		if (sum_p > MAX32) begin
			bz_sat = 32'sh7FFF_FFFF;
		end else if (sum_p < MIN32) begin
			bz_sat = 32'sh8000_0000;
		end else begin
			bz_sat = sum_p[31:0];
		end
	end

	always_comb begin
		if (rd16_r28 > MAX16) begin
			res_sat = 16'sh7FFF;
		end else if (rd16_r28 < MIN16) begin
			res_sat = 16'sh8000;
		end else begin
			res_sat = rd16_r28[15:0];
		end
	end

	// Product write-back
	always_ff @(posedge clk) begin
		case (mstep_s1)
			MS_BX:  bx_q  <= r22[25:0];
			MS_BY:  by_q  <= r22[25:0];
			MS_GX:  acc_q <= cs_w + p_w;
			MS_GY:  acc_q <= sum_p;
			MS_GZ:  bz_q  <= bz_sat;
			MS_BX2: acc_q <= p_w;
			MS_BY2, MS_BZ2, MS_DY: acc_q <= sum_p;
			MS_ANG: ang_q <= ang_w[31:0];
			MS_DX:  acc_q <= p_w;
			MS_DZ:  rdot_q <= rd16_sum[33:0];
			MS_G:   g28_q <= r30[33:0];
			MS_XC1, MS_YC1, MS_ZC1: acc_q <= p_w;
			MS_XC2, MS_YC2, MS_ZC2: crr_q <= rd14_dif[33:0];
			MS_XT2, MS_YT2, MS_ZT2: acc_q <= r30;
			MS_XT1, MS_YT1, MS_ZT1: acc_q <= acc_q + r14;
			MS_XT3: res_x_q <= res_sat;
			MS_YT3: res_y_q <= res_sat;
			MS_ZT3: res_z_q <= res_sat;
			default: ;
		endcase
	end

	// Item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			amp_q <= rf_amplitude;
			ph_q  <= rf_phase;
			gx_q  <= grad_x;
			gy_q  <= grad_y;
			gz_q  <= grad_z;
		end
	end

	// Magnetization state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mag_x_q <= '0;
			mag_y_q <= '0;
			mag_z_q <= '0;
		end else if (cmd.load && restart) begin
			mag_x_q <= imx_q;
			mag_y_q <= imy_q;
			mag_z_q <= imz_q;
		end else if (cmd.commit) begin
			mag_x_q <= res_x_q;
			mag_y_q <= res_y_q;
			mag_z_q <= res_z_q;
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_x_q <= mag_x_q;
			out_y_q <= mag_y_q;
			out_z_q <= mag_z_q;
		end
	end

	assign mag_x = out_x_q;
	assign mag_y = out_y_q;
	assign mag_z = out_z_q;

endmodule

### rtl/core/brs_ctrl.sv
module brs_ctrl import brs_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	input  sts_t sts,
	output cmd_t cmd
);

	localparam logic [CNT_W-1:0] LAST_COR = CNT_W'(CORDIC_STAGES - 1);
	localparam logic [CNT_W-1:0] LAST_SQ  = CNT_W'(SQRT_STEPS - 1);
	localparam logic [CNT_W-1:0] LAST_DV  = CNT_W'(DIV_STEPS - 1);

	st_t              state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	mstep_t           step_q, step_d;
	logic             bub_q, bub_d;
	logic             rot_q, rot_d;
	logic             out_valid_q, out_valid_d;
	logic             can_out;

	assign can_out = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cnt_q       <= '0;
			step_q      <= MS_NOP;
			bub_q       <= 1'b0;
			rot_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			step_q      <= step_d;
			bub_q       <= bub_d;
			rot_q       <= rot_d;
			out_valid_q <= out_valid_d;
		end
	end

	// Next state
	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		step_d      = step_q;
		bub_d       = bub_q;
		rot_d       = rot_q;
		out_valid_d = out_valid_q && out_stall;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_CINI;
					rot_d   = 1'b0;
				end
			end
			ST_CINI: begin
				state_d = ST_CROT;
				cnt_d   = '0;
			end
			ST_CROT: begin
				if (cnt_q == LAST_COR) begin
					cnt_d = '0;
					if (rot_q) begin
						state_d = ST_DVI;
					end else begin
						state_d = ST_MUL;
						step_d  = MS_BX;
						bub_d   = 1'b0;
					end
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_MUL: begin
				// each issue is followed by a bubble in which its product is written back
				if (!bub_q) begin
					bub_d = 1'b1;
				end else begin
					bub_d = 1'b0;
					if (step_q == MS_BZ2) begin
						state_d = ST_SQI;
					end else if (step_q == MS_ANG) begin
						state_d = ST_CINI;
						rot_d   = 1'b1;
					end else if (step_q == MS_ZT3) begin
						state_d = ST_CMT;
					end else begin
						step_d = mstep_t'(step_q + 5'd1);
					end
				end
			end
			ST_SQI: begin
				state_d = ST_SQ;
				cnt_d   = '0;
			end
			ST_SQ: begin
				if (cnt_q == LAST_SQ) begin
					state_d = ST_CHK;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_CHK: begin
				if (sts.norm_zero) begin
					state_d = ST_FIN;
				end else begin
					state_d = ST_MUL;
					step_d  = MS_ANG;
					bub_d   = 1'b0;
				end
			end
			ST_DVI: begin
				state_d = ST_DV;
				cnt_d   = '0;
			end
			ST_DV: begin
				if (cnt_q == LAST_DV) begin
					state_d = ST_MUL;
					step_d  = MS_DX;
					bub_d   = 1'b0;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			ST_CMT: state_d = ST_FIN;
			ST_FIN: begin
				if (can_out) begin
					state_d     = ST_IDLE;
					out_valid_d = 1'b1;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Commands
	always_comb begin
		cmd      = '0;
		cmd.mstep = MS_NOP;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			ST_CINI: begin
				cmd.cor_init = 1'b1;
				cmd.cor_rot  = rot_q;
			end
			ST_CROT: begin
				cmd.cor_step = 1'b1;
				cmd.cor_idx  = IDX_W'(cnt_q);
			end
			ST_MUL:  cmd.mstep    = bub_q ? MS_NOP : step_q;
			ST_SQI:  cmd.sq_init  = 1'b1;
			ST_SQ:   cmd.sq_step  = 1'b1;
			ST_DVI:  cmd.dv_init  = 1'b1;
			ST_DV:   cmd.dv_step  = 1'b1;
			ST_CMT:  cmd.commit   = 1'b1;
			ST_FIN:  cmd.out_load = can_out;
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/bloch_rotation_step.sv
// Channel  | Direction | Handshake            | Beat contents
// input    | in        | in_valid / in_stall  | rf_amplitude rf_phase grad_x/y/z restart
// result   | out       | out_valid / out_stall| mag_x mag_y mag_z
// config   | in        | cfg_valid / cfg_ready| cfg_index cfg_data
//
// One item at a time. The two CORDIC passes, the 32-step square root, the
// 31-step divider and the shared multiplier, with a write-back bubble after
// each issue, set the time from accept to result; a zero field skips the
// second CORDIC pass, the divider and the rotation steps.
// Reset clears control and magnetization and sets config to its defaults; no clearing pass.
// A result waiting under out_stall holds the result register; the next item
// is still accepted and its result waits for the register to free up.
module bloch_rotation_step import brs_pkg::*; #(
	parameter int CORDIC_STAGES = CORDIC_STAGES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] rf_amplitude,
	input  logic [15:0]        rf_phase,
	input  logic signed [15:0] grad_x,
	input  logic signed [15:0] grad_y,
	input  logic signed [15:0] grad_z,
	input  logic               restart,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] mag_x,
	output logic signed [15:0] mag_y,
	output logic signed [15:0] mag_z,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data
);

	cmd_t cmd;
	sts_t sts;

	assign cfg_ready = 1'b1;

	brs_ctrl #(
		.CORDIC_STAGES (CORDIC_STAGES)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	brs_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_valid && cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.rf_amplitude (rf_amplitude),
		.rf_phase     (rf_phase),
		.grad_x       (grad_x),
		.grad_y       (grad_y),
		.grad_z       (grad_z),
		.restart      (restart),
		.mag_x        (mag_x),
		.mag_y        (mag_y),
		.mag_z        (mag_z)
	);

endmodule

### sim/testbench.sv
module testbench import brs_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int  STAGES    = 16;
	localparam int  CYC_LIMIT = 1500000;
	localparam int  HOLD_CYC  = 500;

	typedef struct {
		logic signed [15:0] amp;
		logic [15:0]        phase;
		logic signed [15:0] gx, gy, gz;
		logic               restart;
	} pulse_t;

	typedef struct {
		logic [15:0] x, y, z;
	} mag_t;

	// Scoreboard: own copy of config and magnetization, queue of expected beats
	class bloch_scoreboard;
		logic [15:0] cs, px, py, pz, dt, imx, imy, imz;
		logic [15:0] mx_r, my_r, mz_r;
		mag_t        expected_mag[$];
		int          errors;
		longint      atan_t[24];

		function void reset_state();
			cs = 0; px = 0; py = 0; pz = 0; dt = 16'd1024;
			imx = 0; imy = 0; imz = 16'd16384;
			mx_r = 0; my_r = 0; mz_r = 0;
			errors = 0;
			atan_t = '{536870912, 316933406, 167458907, 85004756, 42667331,
				21354465, 10679838, 5340245, 2670162, 1335087, 667544,
				333772, 166886, 83443, 41722, 20861, 10430, 5215,
				2608, 1304, 652, 326, 163, 81};
		endfunction

		function void write_reg(cfg_reg_t idx, logic [15:0] d);
			case (idx)
				REG_CHEM_SHIFT: cs = d;
				REG_POS_X:      px = d;
				REG_POS_Y:      py = d;
				REG_POS_Z:      pz = d;
				REG_TIME_STEP:  dt = d;
				REG_INIT_MX:    imx = d;
				REG_INIT_MY:    imy = d;
				REG_INIT_MZ:    imz = d;
				default: ;
			endcase
		endfunction

		function longint sx(logic [15:0] v);
			return longint'($signed(v));
		endfunction

		// round half up then drop s bits
		function longint rnd(longint v, int s);
			return (v + (longint'(1) <<< (s - 1))) >>> s;
		endfunction

		function longint clampv(longint v, longint lo, longint hi);
			return v < lo ? lo : (v > hi ? hi : v);
		endfunction

		function void sincos(logic [31:0] ang, output longint c, output longint s);
			logic   neg;
			longint x, y, z, dx, dy;
			neg = 0;
			x = 652032875;
			y = 0;
			if (ang[31:30] == 2'd1 || ang[31:30] == 2'd2) begin
				ang = ang - 32'h8000_0000;
				neg = 1;
			end
			z = longint'($signed(ang));
			for (int i = 0; i < STAGES && i < 24; i++) begin
				dx = y >>> i;
				dy = x >>> i;
				if (z >= 0) begin
					x -= dx; y += dy; z -= atan_t[i];
				end else begin
					x += dx; y -= dy; z += atan_t[i];
				end
			end
			c = neg ? -x : x;
			s = neg ? -y : y;
		endfunction

		function longint unsigned int_sqrt(longint unsigned v);
			longint unsigned res, b;
			res = 0;
			b = 64'd1 << 62;
			while (b > v) b >>= 2;
			while (b != 0) begin
				if (v >= res + b) begin
					v -= res + b;
					res = (res >> 1) + b;
				end else begin
					res >>= 1;
				end
				b >>= 2;
			end
			return res;
		endfunction

		function longint unit_axis(longint b, longint unsigned nrm);
			longint unsigned m;
			longint q;
			m = b < 0 ? -b : b;
			q = longint'(((m << 30) + (nrm >> 1)) / nrm);
			return b < 0 ? -q : q;
		endfunction

		function logic [15:0] rot_comp(longint m, longint cr, longint g28, longint nk,
				longint ct, longint st);
			longint t1, t2, t3;
			t1 = rnd((m * 65536) * ct, 30);
			t2 = rnd(rnd(cr, 14) * st, 30);
			t3 = rnd(g28 * nk, 28);
			return 16'(clampv(rnd(t1 + t2 + t3, 16), -32768, 32767));
		endfunction

		// advance the magnetization by one pulse sample and queue the beat
		function void note_pulse(pulse_t p);
			longint pc, ps, bx, by, bz, mx, my, mz, ct, st, nx, ny, nz, dot, g28;
			longint unsigned n2, nrm;
			logic [31:0] ang;
			mag_t e;
			if (p.restart) begin
				mx_r = imx; my_r = imy; mz_r = imz;
			end
			mx = sx(mx_r); my = sx(my_r); mz = sx(mz_r);
			sincos({p.phase, 16'h0}, pc, ps);
			bx = rnd(longint'(p.amp) * pc, 22);
			by = rnd(longint'(p.amp) * ps, 22);
			bz = sx(cs) * 256 + longint'(p.gx) * sx(px) + longint'(p.gy) * sx(py)
				+ longint'(p.gz) * sx(pz);
			bz = clampv(bz, -64'sd2147483648, 64'sd2147483647);
			n2 = longint'(bx * bx) + longint'(by * by) + longint'(bz * bz);
			nrm = int_sqrt(n2);
			if (nrm != 0) begin
				ang = 32'((nrm * longint'(dt) + 8) >> 4);
				sincos(ang, ct, st);
				nx = unit_axis(bx, nrm);
				ny = unit_axis(by, nrm);
				nz = unit_axis(bz, nrm);
				dot = nx * mx + ny * my + nz * mz;
				g28 = rnd(rnd(dot, 16) * ((longint'(1) <<< 30) - ct), 30);
				mx_r = rot_comp(mx, ny * mz - nz * my, g28, nx, ct, st);
				my_r = rot_comp(my, nz * mx - nx * mz, g28, ny, ct, st);
				mz_r = rot_comp(mz, nx * my - ny * mx, g28, nz, ct, st);
			end
			e.x = mx_r; e.y = my_r; e.z = mz_r;
			expected_mag.push_back(e);
		endfunction

		task report(string what, logic [15:0] got, logic [15:0] want);
			$display("mismatch %s: got %0d want %0d at %0t", what,
				$signed(got), $signed(want), $time);
			errors++;
		endtask

		task check_mag(logic [15:0] x, logic [15:0] y, logic [15:0] z);
			mag_t e;
			if (expected_mag.size() == 0) begin
				$display("unexpected result beat at %0t", $time);
				errors++;
			end else begin
				e = expected_mag.pop_front();
				if (x !== e.x) report("mag_x", x, e.x);
				if (y !== e.y) report("mag_y", y, e.y);
				if (z !== e.z) report("mag_z", z, e.z);
			end
		endtask
	endclass

	logic               clk, arst_n;
	logic               in_valid, in_stall, restart;
	logic signed [15:0] rf_amplitude, grad_x, grad_y, grad_z;
	logic [15:0]        rf_phase;
	logic               out_valid, out_stall;
	logic signed [15:0] mag_x, mag_y, mag_z;
	logic               cfg_valid, cfg_ready;
	logic [2:0]         cfg_index;
	logic [15:0]        cfg_data;

	bloch_scoreboard sb;
	bit              idle_on;
	bit              long_hold;
	int              cycles;

	bloch_rotation_step #(.CORDIC_STAGES(STAGES)) dut (.*);

	// clock
	always begin
		clk = 1'b0; #5;
		clk = 1'b1; #5;
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYC_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// monitor: sample beats at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) sb.write_reg(cfg_reg_t'(cfg_index), cfg_data);
			if (in_valid && !in_stall)
				sb.note_pulse('{rf_amplitude, rf_phase, grad_x, grad_y, grad_z, restart});
			if (out_valid && !out_stall) sb.check_mag(mag_x, mag_y, mag_z);
		end
	end

	// receiver: random stall bursts, plus one long hold on request
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				out_stall = 1'b1;
				repeat (HOLD_CYC) @(negedge clk);
				out_stall = 1'b0;
				long_hold = 0;
			end else if (idle_on && $urandom_range(0, 7) == 0) begin
				out_stall = 1'b1;
				repeat ($urandom_range(1, 14)) @(negedge clk);
				out_stall = 1'b0;
			end
		end
	end

	task automatic write_cfg(cfg_reg_t idx, logic [15:0] d);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = d;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// drive one pulse beat; valid stays high into the next beat unless a gap is taken
	task automatic send_pulse(logic signed [15:0] a, logic [15:0] ph, logic signed [15:0] gx,
			logic signed [15:0] gy, logic signed [15:0] gz, logic rs);
		in_valid     = 1'b1;
		rf_amplitude = a;
		rf_phase     = ph;
		grad_x       = gx;
		grad_y       = gy;
		grad_z       = gz;
		restart      = rs;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 14)) @(negedge clk);
		end
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (sb.expected_mag.size() != 0) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	function automatic logic [15:0] pick16();
		case ($urandom_range(0, 5))
			0: return 16'h8000;
			1: return 16'h7FFF;
			2: return 16'($urandom_range(0, 255));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic random_pulse();
		logic signed [15:0] a;
		logic signed [15:0] gx, gy, gz;
		a  = pick16();
		gx = ($urandom_range(0, 2) == 0) ? 16'sd0 : pick16();
		gy = ($urandom_range(0, 2) == 0) ? 16'sd0 : pick16();
		gz = ($urandom_range(0, 2) == 0) ? 16'sd0 : pick16();
		if ($urandom_range(0, 15) == 0) begin
			a = 0; gx = 0; gy = 0; gz = 0;
		end
		send_pulse(a, 16'($urandom), gx, gy, gz, $urandom_range(0, 11) == 0);
	endtask

	task automatic random_config();
		for (int r = 0; r < 8; r++) begin
			if (r == REG_TIME_STEP && $urandom_range(0, 1))
				write_cfg(cfg_reg_t'(r), 16'($urandom_range(0, 4096)));
			else
				write_cfg(cfg_reg_t'(r), pick16());
		end
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		cycles       = 0;
		idle_on      = 0;
		long_hold    = 0;
		in_valid     = 1'b0;
		rf_amplitude = 0;
		rf_phase     = 0;
		grad_x       = 0;
		grad_y       = 0;
		grad_z       = 0;
		restart      = 1'b0;
		cfg_valid    = 1'b0;
		cfg_index    = REG_CHEM_SHIFT;
		cfg_data     = 0;
		arst_n       = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: never restarted, zero field, phase quadrants, amplitude extremes
		send_pulse(16'sd256, 16'h0000, 0, 0, 0, 1'b0);
		send_pulse(16'sd0, 16'h1234, 0, 0, 0, 1'b1);
		send_pulse(16'sd256, 16'h0000, 0, 0, 0, 1'b0);
		send_pulse(16'sd32767, 16'h4000, 0, 0, 0, 1'b0);
		send_pulse(-16'sd32768, 16'h8000, 0, 0, 0, 1'b0);
		send_pulse(16'sd1000, 16'hC000, 0, 0, 0, 1'b0);
		send_pulse(-16'sd5, 16'hFFFF, 16'sh7FFF, -16'sh8000, 16'sh7FFF, 1'b1);
		send_pulse(16'sd1, 16'h3FFF, 0, 0, 0, 1'b0);
		drain();

		// saturated Bz and extreme initial magnetization
		write_cfg(REG_CHEM_SHIFT, 16'h7FFF);
		write_cfg(REG_POS_X, 16'h7FFF);
		write_cfg(REG_POS_Y, 16'h7FFF);
		write_cfg(REG_POS_Z, 16'h8000);
		write_cfg(REG_TIME_STEP, 16'hFFFF);
		write_cfg(REG_INIT_MX, 16'h7FFF);
		write_cfg(REG_INIT_MY, 16'h8000);
		write_cfg(REG_INIT_MZ, 16'h7FFF);
		send_pulse(16'sd32767, 16'h2000, 16'sh7FFF, 16'sh7FFF, -16'sh8000, 1'b1);
		send_pulse(-16'sd32768, 16'hA000, -16'sh8000, -16'sh8000, 16'sh7FFF, 1'b0);
		send_pulse(16'sd0, 16'h0000, 0, 0, 0, 1'b0);
		send_pulse(16'sd77, 16'h6000, 16'sh0100, 0, 0, 1'b1);
		drain();
		write_cfg(REG_CHEM_SHIFT, 16'h8000);
		write_cfg(REG_TIME_STEP, 16'h0000);
		send_pulse(16'sd512, 16'hE000, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 1'b1);
		send_pulse(-16'sd200, 16'h5555, 0, 16'sh1234, 0, 1'b0);
		drain();

		// long receiver hold while the sender keeps offering
		write_cfg(REG_TIME_STEP, 16'd1024);
		long_hold = 1;
		repeat (6) random_pulse();
		drain();

		// random phases with idling on both sides
		idle_on = 1;
		for (int ph = 0; ph < 6; ph++) begin
			random_config();
			send_pulse(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
				16'($urandom), 1'b1);
			repeat (110) random_pulse();
			drain();
		end

		// closing stretch without idling
		idle_on = 0;
		random_config();
		repeat (40) random_pulse();
		drain();
		repeat (400) @(negedge clk);

		if (sb.errors == 0 && sb.expected_mag.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
